[design/smfp_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the SMBus frame builder.
// Used by every module of the block; depends on nothing.
package smfp_pkg;

  // Largest payload a frame may carry; longer lengths are clipped to it
  localparam logic [7:0] MAX_PAYLOAD = 8'd252;

  // SMBus PEC polynomial x^8+x^2+x+1 without the top bit
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Register reset values
  localparam logic [7:0] CMD_RESET  = 8'h0F;
  localparam logic [6:0] DEST_RESET = 7'h1D;
  localparam logic [7:0] SRC_RESET  = 8'h21;

  // Register indexes on the configuration port
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_CMD  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEST = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SRC  = 2'd2;
  localparam int unsigned PADDR_W = 4;

  // Queue between classifier and sequencer
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One classified word: a payload byte and what it opens or closes
  typedef struct packed {
    logic       start;  // open a new frame with header bytes
    logic       last;   // close the frame with the PEC byte
    logic [7:0] data;   // payload byte
    logic [7:0] count;  // byte count field, valid with start
  } entry_t;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [7:0] cmd_byte;
    logic [6:0] dest_address;
    logic [7:0] source_address;
  } cfg_t;

  // Fold one byte into a running CRC-8
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[design/smfp_fifo.sv]
// Short word queue between the classifier and the frame sequencer.
// Depends on smfp_pkg for the entry type and depth.
module smfp_fifo
  import smfp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  entry_t                push_data_i,
  input  logic                  pop_i,
  output entry_t                head_o,
  output logic                  full_o,
  output logic                  empty_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/smfp_front.sv]
// Input classifier: tracks the open frame and turns each accepted byte of a frame into a queue word.
// Depends on smfp_pkg for the entry type and length limit.
module smfp_front
  import smfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] payload_byte_i,
  input  logic       is_first_i,
  input  logic [7:0] payload_length_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     push_data_o
);

  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] len_sat;
  logic       accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Clip the length into 1..MAX_PAYLOAD
  always_comb begin
    len_sat = payload_length_i;
    if (payload_length_i == 8'd0) begin
      len_sat = 8'd1;
    end else if (payload_length_i > MAX_PAYLOAD) begin
      len_sat = MAX_PAYLOAD;
    end
  end

  // Classify: start a frame, continue it, or drop a stray byte
  always_comb begin
    bytes_left_d      = bytes_left_q;
    push_o            = 1'b0;
    push_data_o.start = is_first_i;
    push_data_o.data  = payload_byte_i;
    push_data_o.count = len_sat + 8'd1;
    push_data_o.last  = 1'b0;
    if (accept) begin
      if (is_first_i) begin
        bytes_left_d     = len_sat - 8'd1;
        push_o           = 1'b1;
        push_data_o.last = (len_sat == 8'd1);
      end else if (bytes_left_q != 8'd0) begin
        bytes_left_d     = bytes_left_q - 8'd1;
        push_o           = 1'b1;
        push_data_o.last = (bytes_left_q == 8'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 8'd0;
    end else begin
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

[design/smfp_back.sv]
// Frame sequencer: queue words to header/payload/PEC bytes, one per cycle unless stalled.
// Depends on smfp_pkg for the entry and config types and the CRC-8 update.
module smfp_back
  import smfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  entry_t     head_i,
  input  logic       head_valid_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_CMD,
    PH_CNT,
    PH_SRC,
    PH_DATA,
    PH_PEC
  } phase_e;

  phase_e     phase_q, phase_d, cur;
  logic [7:0] crc_q, crc_d;
  logic [7:0] addr_crc_q;
  logic [7:0] byte_sel;
  logic [7:0] crc_base;
  logic       last_sel;
  logic       done;
  logic       step;
  logic       out_valid_q;
  logic [7:0] frame_byte_q;
  logic       frame_last_q;

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = frame_byte_q;
  assign frame_last_o = frame_last_q;

  assign step  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = step && done;

  // Pick the phase for this cycle: a fresh word opens with header or payload
  always_comb begin
    if (phase_q == PH_HEAD) begin
      cur = head_i.start ? PH_CMD : PH_DATA;
    end else begin
      cur = phase_q;
    end
  end

  // Select the byte, the next phase and whether the word is used up
  always_comb begin
    byte_sel = head_i.data;
    last_sel = 1'b0;
    phase_d  = PH_HEAD;
    done     = 1'b0;
    unique case (cur)
      PH_HEAD: begin
        byte_sel = head_i.data;
      end
      PH_CMD: begin
        byte_sel = cfg_i.cmd_byte;
        phase_d  = PH_CNT;
      end
      PH_CNT: begin
        byte_sel = head_i.count;
        phase_d  = PH_SRC;
      end
      PH_SRC: begin
        byte_sel = cfg_i.source_address;
        phase_d  = PH_DATA;
      end
      PH_DATA: begin
        byte_sel = head_i.data;
        if (head_i.last) begin
          phase_d = PH_PEC;
        end else begin
          done = 1'b1;
        end
      end
      PH_PEC: begin
        byte_sel = crc_q;
        last_sel = 1'b1;
        done     = 1'b1;
      end
      default: begin
        byte_sel = head_i.data;
      end
    endcase
  end

  // Fold the emitted byte into the PEC; the command byte restarts from the address CRC
  assign crc_base = (cur == PH_CMD) ? addr_crc_q : crc_q;
  assign crc_d    = last_sel ? crc_q : crc8_byte(crc_base, byte_sel);

  // Hold phase, PEC and the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEAD;
      crc_q        <= 8'd0;
      addr_crc_q   <= crc8_byte(8'd0, {DEST_RESET, 1'b0});
      out_valid_q  <= 1'b0;
      frame_byte_q <= 8'd0;
      frame_last_q <= 1'b0;
    end else begin
      addr_crc_q <= crc8_byte(8'd0, {cfg_i.dest_address, 1'b0});
      if (step) begin
        phase_q      <= phase_d;
        crc_q        <= crc_d;
        out_valid_q  <= 1'b1;
        frame_byte_q <= byte_sel;
        frame_last_q <= last_sel;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[design/smbus_mctp_tx_framer_pec.sv]
// SMBus block-write framer with PEC: config registers, classifier, word queue, sequencer.
// The first frame byte of a payload word is registered in the word queue, then in the sequencer output.
// Throughput: one output byte per cycle while the sink is ready; a first word expands to 4 or 5 bytes,
// others to 1 or 2, so input words are taken one per cycle while the 4-entry queue has room.
// Reset (rst_ni low, asynchronous) closes any open frame, empties the queue and restores
// the registers to command 0x0F, destination 0x1D and source 0x21.
module smbus_mctp_tx_framer_pec
  import smfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         payload_byte_i,
  input  logic               is_first_i,
  input  logic [7:0]         payload_length_i,
  // output words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         frame_byte_o,
  output logic               frame_last_o
);

  logic [7:0]            cmd_byte_q;
  logic [6:0]            dest_address_q;
  logic [7:0]            source_address_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;
  cfg_t                  cfg;
  entry_t                push_data;
  entry_t                head;
  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;
  logic [FIFO_CNT_W-1:0] count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_byte_q       <= CMD_RESET;
      dest_address_q   <= DEST_RESET;
      source_address_q <= SRC_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == REG_CMD) begin
        cmd_byte_q <= pwdata[7:0];
      end
      if (reg_idx == REG_DEST) begin
        dest_address_q <= pwdata[6:0];
      end
      if (reg_idx == REG_SRC) begin
        source_address_q <= pwdata[7:0];
      end
    end
  end

  // Read back registers
  always_comb begin
    prdata = 32'd0;
    if (reg_idx == REG_CMD) begin
      prdata = {24'd0, cmd_byte_q};
    end else if (reg_idx == REG_DEST) begin
      prdata = {25'd0, dest_address_q};
    end else if (reg_idx == REG_SRC) begin
      prdata = {24'd0, source_address_q};
    end
  end

  assign cfg.cmd_byte       = cmd_byte_q;
  assign cfg.dest_address   = dest_address_q;
  assign cfg.source_address = source_address_q;

  smfp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .payload_byte_i   (payload_byte_i),
    .is_first_i       (is_first_i),
    .payload_length_i (payload_length_i),
    .full_i           (full),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  smfp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty),
    .count_o     (count)
  );

  smfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (head),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue occupancy lost a word");
`endif

endmodule

[test/smfp_frame_checker.sv]
// Frame checker for the SMBus block-write framer: watches the register port and both word
// channels, builds the expected frame bytes with PEC and compares every word the block sends.
// Depends on smfp_pkg for register indexes, reset values, the PEC polynomial and payload limit.
module smfp_frame_checker
  import smfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         payload_byte_i,
  input  logic               is_first_i,
  input  logic [7:0]         payload_length_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [7:0]         frame_byte_i,
  input  logic               frame_last_i,
  output int unsigned        error_count_o,
  output int unsigned        pending_bytes_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  wire_byte_t  wire_bytes_q[$];
  wire_byte_t  head_byte;
  int unsigned errors;

  // Shadow registers and frame state
  logic [7:0] cmd_reg;
  logic [6:0] dest_reg;
  logic [7:0] src_reg;
  logic [7:0] pec_acc;
  logic [7:0] payload_left;

  // Serial CRC-8, one bit at a time, most significant first
  function automatic logic [7:0] pec_fold(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc;
    for (int b = 7; b >= 0; b--) begin
      if (r[7] ^ data[b]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Queue one frame byte; every byte but the PEC itself goes into the PEC
  task automatic queue_byte(input logic [7:0] data, input logic last);
    wire_bytes_q.push_back(wire_byte_t'{data: data, last: last});
    if (!last) begin
      pec_acc = pec_fold(pec_acc, data);
    end
  endtask

  // Expand one accepted payload word into the frame bytes it causes
  task automatic frame_bytes_for_word(input logic [7:0] data, input logic first,
                                      input logic [7:0] len_field);
    logic [7:0] len_eff;
    if (first) begin
      len_eff = len_field;
      if (len_eff == 8'd0) begin
        len_eff = 8'd1;
      end
      if (len_eff > MAX_PAYLOAD) begin
        len_eff = MAX_PAYLOAD;
      end
      pec_acc = pec_fold(8'h00, {dest_reg, 1'b0});
      queue_byte(cmd_reg, 1'b0);
      queue_byte(len_eff + 8'd1, 1'b0);
      queue_byte(src_reg, 1'b0);
      payload_left = len_eff;
    end else if (payload_left == 8'd0) begin
      // drop: no frame open
      return;
    end
    queue_byte(data, 1'b0);
    payload_left = payload_left - 8'd1;
    if (payload_left == 8'd0) begin
      queue_byte(pec_acc, 1'b1);
    end
  endtask

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] seen);
    errors++;
    $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, seen);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_reg = CMD_RESET;
      dest_reg = DEST_RESET;
      src_reg = SRC_RESET;
      pec_acc = 8'h00;
      payload_left = 8'h00;
      wire_bytes_q.delete();
      errors = 0;
      error_count_o <= 0;
      pending_bytes_o <= 0;
    end else begin
      // Compare each delivered word with the oldest expected byte
      if (out_valid_i && out_ready_i) begin
        if (wire_bytes_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %02h last %0b",
                   $time, frame_byte_i, frame_last_i);
        end else begin
          head_byte = wire_bytes_q.pop_front();
          if (frame_byte_i !== head_byte.data) begin
            report("frame_byte", head_byte.data, frame_byte_i);
          end
          if (frame_last_i !== head_byte.last) begin
            report("frame_last", {7'd0, head_byte.last}, {7'd0, frame_last_i});
          end
        end
      end

      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_CMD: begin
            cmd_reg = pwdata_i[7:0];
          end
          REG_DEST: begin
            dest_reg = pwdata_i[6:0];
          end
          REG_SRC: begin
            src_reg = pwdata_i[7:0];
          end
          default: begin
          end
        endcase
      end

      // Predict the bytes of each accepted payload word
      if (in_valid_i && in_ready_i) begin
        frame_bytes_for_word(payload_byte_i, is_first_i, payload_length_i);
      end

      error_count_o <= errors;
      pending_bytes_o <= wire_bytes_q.size();
    end
  end

endmodule

[test/tb_top.sv]
// Top of the framer testbench: clock, reset, register writes, payload and sink traffic.
// Depends on smfp_pkg, the framer RTL and smfp_frame_checker, which predicts and compares.
module tb_top
  import smfp_pkg::*;
();

  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         payload_byte_i;
  logic               is_first_i;
  logic [7:0]         payload_length_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         frame_byte_o;
  logic               frame_last_o;

  int unsigned error_count;
  int unsigned pending_bytes;

  // Stimulus bookkeeping
  int unsigned words_sent;
  int unsigned items_done;
  bit          frame_open;

  smbus_mctp_tx_framer_pec u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .payload_byte_i   (payload_byte_i),
    .is_first_i       (is_first_i),
    .payload_length_i (payload_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .frame_last_o     (frame_last_o)
  );

  smfp_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .payload_byte_i   (payload_byte_i),
    .is_first_i       (is_first_i),
    .payload_length_i (payload_length_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_i     (frame_byte_o),
    .frame_last_i     (frame_last_o),
    .error_count_o    (error_count),
    .pending_bytes_o  (pending_bytes)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one payload word and hold it until taken; idle now and then except in a quiet stretch
  task automatic push_word(input logic [7:0] data, input logic first, input logic [7:0] len);
    while (!(words_sent >= 150 && words_sent < 230) && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    payload_byte_i   <= data;
    is_first_i       <= first;
    payload_length_i <= len;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    words_sent++;
  endtask

  // Write one register with junk in the unused upper bits
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
    logic [31:0] junk;
    junk = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[31:8], value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering words, drain every expected byte, then let the block settle
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Short packets, length clipping, zero length, restarts and stray words
  task automatic directed_words();
    push_word(8'h00, 1'b1, 8'd1);    // single-byte packet: header and PEC together
    push_word(8'hFF, 1'b1, 8'd1);
    push_word(8'hA5, 1'b1, 8'd0);    // zero length acts as one
    push_word(8'h5A, 1'b0, 8'hFF);   // stray word with no frame open: dropped
    push_word(8'h12, 1'b1, 8'd3);
    push_word(8'h34, 1'b0, 8'h00);
    push_word(8'h56, 1'b0, 8'h80);
    push_word(8'h80, 1'b1, 8'd255);  // clipped to the payload limit
    push_word(8'h01, 1'b0, 8'h7F);
    push_word(8'h7F, 1'b1, 8'd2);    // restart abandons the open frame
    push_word(8'hFE, 1'b0, 8'h00);
    push_word(8'hC3, 1'b1, 8'd252);
    push_word(8'h3C, 1'b0, 8'hAA);
    push_word(8'h96, 1'b1, 8'd253);
    push_word(8'h69, 1'b1, 8'd2);
    push_word(8'hF0, 1'b0, 8'h55);
    push_word(8'h0F, 1'b0, 8'h01);   // stray after close
    items_done += 15;
  endtask

  // One random packet or stray words: mostly short and complete, some long, clipped, empty or abandoned
  task automatic random_frame();
    int unsigned pick;
    int unsigned eff;
    int unsigned n_bytes;
    logic [7:0]  len_field;
    pick = $urandom_range(99);
    if (!frame_open && pick >= 94) begin
      repeat ($urandom_range(2, 1)) begin
        push_word(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
      end
      return;
    end
    if (pick < 70) begin
      len_field = 8'($urandom_range(6, 1));
    end else if (pick < 84) begin
      len_field = 8'($urandom_range(30, 7));
    end else if (pick < 87) begin
      len_field = 8'($urandom_range(252, 31));
    end else if (pick < 90) begin
      len_field = 8'($urandom_range(255, 252));
    end else begin
      len_field = 8'd0;
    end
    eff = (len_field == 8'd0) ? 32'd1 :
          32'((len_field > MAX_PAYLOAD) ? MAX_PAYLOAD : len_field);
    n_bytes = eff;
    if (eff > 1 && $urandom_range(99) < ((eff > 30) ? 50 : 10)) begin
      n_bytes = $urandom_range(eff - 1, 1);
    end
    push_word(8'($urandom_range(255)), 1'b1, len_field);
    for (int k = 1; k < n_bytes; k++) begin
      push_word(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
    end
    frame_open = (n_bytes < eff);
    items_done += n_bytes;
  endtask

  // Run random packets until the budget is spent and the last frame is closed
  task automatic random_phase(input int unsigned budget);
    int unsigned goal;
    goal = items_done + budget;
    while (items_done < goal || frame_open) begin
      random_frame();
    end
  endtask

  // Sink: random stalls, one long hold-off to back up the block, and a stretch always ready
  initial begin : sink
    int unsigned words_taken;
    int unsigned hold_left;
    bit          held;
    words_taken = 0;
    hold_left   = 0;
    held        = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        words_taken++;
      end
      if (!held && words_taken >= 120) begin
        held      = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (words_taken >= 300 && words_taken < 500) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 20);
      end
    end
  end

  // End the run as failed if the test has not finished by the cycle limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] cfg_rand;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    payload_byte_i   <= 8'h00;
    is_first_i       <= 1'b0;
    payload_length_i <= 8'h00;
    words_sent = 0;
    items_done = 0;
    frame_open = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values
    directed_words();
    random_phase(PHASE_ITEMS);

    // All registers at zero
    settle();
    write_reg(REG_CMD, 8'h00);
    write_reg(REG_DEST, 8'h80);
    write_reg(REG_SRC, 8'h00);
    random_phase(PHASE_ITEMS);

    // All registers at their top value
    settle();
    write_reg(REG_CMD, 8'hFF);
    write_reg(REG_DEST, 8'h7F);
    write_reg(REG_SRC, 8'hFF);
    random_phase(PHASE_ITEMS);

    // Random register values
    settle();
    cfg_rand = $urandom();
    write_reg(REG_CMD, cfg_rand[7:0]);
    write_reg(REG_DEST, cfg_rand[15:8]);
    write_reg(REG_SRC, cfg_rand[23:16]);
    random_phase(PHASE_ITEMS);

    settle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
design/smfp_pkg.sv
design/smfp_fifo.sv
design/smfp_front.sv
design/smfp_back.sv
design/smbus_mctp_tx_framer_pec.sv
test/smfp_frame_checker.sv
test/tb_top.sv
